// ----- rtl/coprocessor_status_and_dma_registers_defines.svh -----
// Assertion macros for the coprocessor status and DMA register top level.
`ifndef COPROCESSOR_STATUS_AND_DMA_REGISTERS_DEFINES_SVH
`define COPROCESSOR_STATUS_AND_DMA_REGISTERS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CPSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsd check failed");

// Next-cycle implication, checked outside reset.
`define CPSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsd check failed");

`endif

// ----- rtl/cpsd_pkg.sv -----
// Types and constants of the coprocessor status and DMA register block.
package cpsd_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BREAK = 2'd2,
        OP_TICK  = 2'd3
    } op_t;

    // Interrupt actions reported with each result
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_RAISE = 2'd1,
        ACT_ACK   = 2'd2
    } action_t;

    // Register indexes
    localparam logic [2:0] REG_LOCAL_ADDR = 3'd0;
    localparam logic [2:0] REG_EXT_ADDR   = 3'd1;
    localparam logic [2:0] REG_RD_LENGTH  = 3'd2;
    localparam logic [2:0] REG_WR_LENGTH  = 3'd3;
    localparam logic [2:0] REG_STATUS     = 3'd4;

    localparam int STATUS_BITS       = 15;
    localparam int STATUS_FLAG_PAIRS = 10;
    localparam int OFFSET_BITS       = 12;
    localparam logic [OFFSET_BITS-1:0] LENGTH_MASK = 12'hFF8;
    localparam logic [OFFSET_BITS-1:0] BEAT_BYTES  = 12'd8;

    localparam int DATA_BITS     = 32;
    localparam int IN_TDATA_BITS = 40;

    // Status register command from the front end
    typedef struct packed {
        logic                 write;
        logic                 brk;
        logic [DATA_BITS-1:0] value;
    } status_cmd_t;

endpackage

// ----- rtl/coprocessor_status_and_dma_registers.sv -----
// Top level of the coprocessor status and DMA register block.
//
// Input channel (s_*): one item per bus access, break event or DMA tick.
//   s_tuser carries the operation, s_tdata the register index and write data.
// Output channel (m_*): exactly one result item per input item, in order.
//   m_tdata carries read data, halt bit, interrupt action, unknown-register
//   flag and the DMA beat; m_tlast marks the final beat of a transfer.
// Path: an accepted item goes through the input register, then the result
//   register, whose output drives m_*.
// Throughput: one item per cycle unless m_tready stalls the output; all decode
//   and address arithmetic sits between the input register and the result register.
// A length write latches the current address registers and starts a
//   transfer of ((length & 0xFF8) / 8 + 1) beats; each tick gives one beat.
// Reset: both stages empty, addresses and transfer state zero, status = halted.
// Stall: while m_tready is low the result holds, one more item waits in the
//   input register, and s_tready drops once both are full.
module coprocessor_status_and_dma_registers #(
    parameter int LOCAL_ADDR_BITS    = 13,
    parameter int EXTERNAL_ADDR_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: reg_index[2:0], write_data[34:3], zero fill
    input  logic [cpsd_pkg::IN_TDATA_BITS-1:0] s_tdata,
    // s_tuser: operation[1:0]
    input  logic [1:0]                        s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: read_data[14:0], halted, interrupt_action[1:0], unknown_register,
    //          beat_valid, beat_to_external, beat_external_address,
    //          beat_local_address, zero fill
    output logic [((21 + EXTERNAL_ADDR_BITS + 1 + LOCAL_ADDR_BITS + 7) / 8) * 8 - 1:0]
                                              m_tdata,
    // beat_last
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import cpsd_pkg::*;

`include "coprocessor_status_and_dma_registers_defines.svh"

    localparam int EXT_OUT_BITS   = EXTERNAL_ADDR_BITS + 1;
    localparam int OUT_FIELD_BITS = 21 + EXT_OUT_BITS + LOCAL_ADDR_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Input stage
    logic                 in_valid_reg;
    op_t                  in_op_reg;
    logic [2:0]           in_idx_reg;
    logic [DATA_BITS-1:0] in_data_reg;

    // Result stage
    logic                      out_valid_reg;
    logic [OUT_TDATA_BITS-1:0] out_tdata_reg;
    logic                      out_last_reg;

    // Address and transfer state
    logic [LOCAL_ADDR_BITS-1:0]    local_addr_reg;
    logic [EXTERNAL_ADDR_BITS-1:0] ext_addr_reg;
    logic                          tx_busy_reg;
    logic                          tx_to_ext_reg;
    logic [LOCAL_ADDR_BITS-1:0]    tx_local_base_reg;
    logic [EXTERNAL_ADDR_BITS-1:0] tx_ext_base_reg;
    logic [OFFSET_BITS-1:0]        tx_offset_reg;
    logic [OFFSET_BITS-1:0]        tx_final_reg;

    logic advance;
    logic fire;

    status_cmd_t            status_cmd;
    logic [STATUS_BITS-1:0] status_cur;
    logic [STATUS_BITS-1:0] status_nx;
    action_t                status_action;

    logic [STATUS_BITS-1:0]        read_data_c;
    logic                          unknown_c;
    logic                          beat_valid_c;
    logic                          beat_dir_c;
    logic [EXT_OUT_BITS-1:0]       beat_ext_c;
    logic [LOCAL_ADDR_BITS-1:0]    beat_local_c;
    logic                          beat_last_c;
    logic                          start_c;
    logic                          step_c;
    logic [OUT_TDATA_BITS-1:0]     tdata_c;

    // Handshake: the result stage frees when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg   <= op_t'(s_tuser);
            in_idx_reg  <= s_tdata[2:0];
            in_data_reg <= s_tdata[3 +: DATA_BITS];
        end
    end

    // Status register commands
    always_comb
    begin
        status_cmd.write = fire && (in_op_reg == OP_WRITE) && (in_idx_reg == REG_STATUS);
        status_cmd.brk   = fire && (in_op_reg == OP_BREAK);
        status_cmd.value = in_data_reg;
    end

    cpsd_status u_status (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (status_cmd),
        .status      (status_cur),
        .status_next (status_nx),
        .action      (status_action)
    );

    // Decode the item and form the beat
    always_comb
    begin
        read_data_c  = '0;
        unknown_c    = 1'b0;
        beat_valid_c = 1'b0;
        beat_dir_c   = 1'b0;
        beat_ext_c   = '0;
        beat_local_c = '0;
        beat_last_c  = 1'b0;
        start_c      = 1'b0;
        step_c       = 1'b0;
        unique case (in_op_reg)
            OP_WRITE:
            begin
                unique case (in_idx_reg) inside
                    REG_LOCAL_ADDR, REG_EXT_ADDR, REG_STATUS: ;
                    REG_RD_LENGTH, REG_WR_LENGTH: start_c = 1'b1;
                    default:                      unknown_c = 1'b1;
                endcase
            end
            OP_READ:
            begin
                if (in_idx_reg == REG_STATUS)
                    read_data_c = status_cur;
                else
                    unknown_c = 1'b1;
            end
            OP_BREAK: ;
            OP_TICK:
            begin
                if (tx_busy_reg)
                begin
                    beat_valid_c = 1'b1;
                    beat_dir_c   = tx_to_ext_reg;
                    beat_ext_c   = {1'b0, tx_ext_base_reg} + EXT_OUT_BITS'(tx_offset_reg);
                    beat_local_c = tx_local_base_reg + LOCAL_ADDR_BITS'(tx_offset_reg);
                    beat_last_c  = (tx_offset_reg >= tx_final_reg);
                    step_c       = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Advance addresses and the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg    <= '0;
            ext_addr_reg      <= '0;
            tx_busy_reg       <= 1'b0;
            tx_to_ext_reg     <= 1'b0;
            tx_local_base_reg <= '0;
            tx_ext_base_reg   <= '0;
            tx_offset_reg     <= '0;
            tx_final_reg      <= '0;
        end
        else if (fire)
        begin
            if (in_op_reg == OP_WRITE && in_idx_reg == REG_LOCAL_ADDR)
                local_addr_reg <= in_data_reg[LOCAL_ADDR_BITS-1:0];
            if (in_op_reg == OP_WRITE && in_idx_reg == REG_EXT_ADDR)
                ext_addr_reg <= in_data_reg[EXTERNAL_ADDR_BITS-1:0];
            if (start_c)
            begin
                tx_busy_reg       <= 1'b1;
                tx_to_ext_reg     <= (in_idx_reg == REG_WR_LENGTH);
                tx_local_base_reg <= local_addr_reg;
                tx_ext_base_reg   <= ext_addr_reg;
                tx_offset_reg     <= '0;
                tx_final_reg      <= in_data_reg[OFFSET_BITS-1:0] & LENGTH_MASK;
            end
            else if (step_c)
            begin
                if (beat_last_c)
                    tx_busy_reg <= 1'b0;
                else
                    tx_offset_reg <= tx_offset_reg + BEAT_BYTES;
            end
        end
    end

    // Pack the result fields
    always_comb
    begin
        tdata_c = '0;
        tdata_c[OUT_FIELD_BITS-1:0] = {beat_local_c, beat_ext_c, beat_dir_c, beat_valid_c,
                                       unknown_c, status_action, status_nx[0], read_data_c};
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_tdata_reg <= tdata_c;
            out_last_reg  <= beat_last_c;
        end
    end

    assign m_tdata  = out_tdata_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    // A running transfer never steps past its final offset
    `CPSD_ASSERT_NOW(a_offset_in_range, clk, rst_n, tx_busy_reg, tx_offset_reg <= tx_final_reg)
    // The final beat ends the transfer
    `CPSD_ASSERT_NEXT(a_last_ends, clk, rst_n, fire && beat_last_c && !start_c, !tx_busy_reg)
    // tlast only rides on a beat
    `CPSD_ASSERT_NOW(a_last_is_beat, clk, rst_n, m_tvalid && m_tlast, m_tdata[19])
    // A beat result carries no register side effects
    `CPSD_ASSERT_NOW(a_beat_clean, clk, rst_n, m_tvalid && m_tdata[19],
                     !m_tdata[18] && m_tdata[17:16] == ACT_NONE && m_tdata[14:0] == '0)

endmodule

// ----- rtl/cpsd_status.sv -----
// Status register: halt, broke and flag bits with paired clear/set writes.
module cpsd_status (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cpsd_pkg::status_cmd_t                cmd,
    output logic [cpsd_pkg::STATUS_BITS-1:0]     status,
    output logic [cpsd_pkg::STATUS_BITS-1:0]     status_next,
    output cpsd_pkg::action_t                    action
);
    import cpsd_pkg::*;

    logic [STATUS_BITS-1:0] status_reg;
    logic [STATUS_BITS-1:0] status_nx;
    action_t                action_c;

    // Decode a status write or a break event
    always_comb
    begin
        status_nx = status_reg;
        action_c  = ACT_NONE;
        if (cmd.write)
        begin
            if (cmd.value[0])
                status_nx[0] = 1'b0;
            else if (cmd.value[1])
                status_nx[0] = 1'b1;
            if (cmd.value[2])
                status_nx[1] = 1'b0;
            if (cmd.value[3])
                action_c = ACT_ACK;
            else if (cmd.value[4])
                action_c = ACT_RAISE;
            for (int k = 0; k < STATUS_FLAG_PAIRS; k++)
            begin
                if (cmd.value[5 + 2 * k])
                    status_nx[5 + k] = 1'b0;
                else if (cmd.value[6 + 2 * k])
                    status_nx[5 + k] = 1'b1;
            end
        end
        else if (cmd.brk)
        begin
            if (status_reg[6])
                action_c = ACT_RAISE;
            status_nx[1:0] = 2'b11;
        end
        // Bits 2..4 have no storage
        status_nx[4:2] = 3'b000;
    end

    // Hold the status bits; reset to halted
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_reg <= STATUS_BITS'(1);
        else
            status_reg <= status_nx;
    end

    assign status      = status_reg;
    assign status_next = status_nx;
    assign action      = action_c;

endmodule
